/* rtl/rgbcc_pkg.sv */
`timescale 1ns / 1ps

// Shared types, constants and widths of the RGB color classifier.
package rgbcc_pkg;

  // Default values of the top-level parameters.
  localparam int SAMPLE_BITS_DEF   = 10;
  localparam int HUE_FRAC_BITS_DEF = 12;

  // Fixed widths. Channels are clamped to 8 bits before any arithmetic.
  localparam int CH_W       = 8;
  localparam int LUMA_W     = 16;
  localparam int DIV_W      = 11;   // holds 6 * 255 = 1530
  localparam int SUM_LIM_W  = 16;
  localparam int RAW_LIM_W  = 10;
  localparam int HUE_LIM_W  = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int KIND_W     = 2;
  localparam int CODE_W     = 3;

  localparam logic [CH_W-1:0]   CLAMP_MAX    = 8'd255;
  localparam logic [CH_W-1:0]   GRAY_RED_MIN = 8'd50;
  localparam logic [CH_W-1:0]   BLUE_MIN     = 8'd70;
  localparam logic [LUMA_W-1:0] LUMA_R       = 16'd77;
  localparam logic [LUMA_W-1:0] LUMA_G       = 16'd150;
  localparam logic [LUMA_W-1:0] LUMA_B       = 16'd29;

  // Sample modes. Any other code is full color mode.
  localparam logic [KIND_W-1:0] KIND_BW  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BGW = 2'd1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DARK_SUM    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_SUM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLACK_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_RED_YEL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_YEL_GRN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_GRN_BLU = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_BLU_RED = 3'd7;

  // Reset values of the registers.
  localparam logic [SUM_LIM_W-1:0] DARK_SUM_RST    = 16'd6503;
  localparam logic [SUM_LIM_W-1:0] BRIGHT_SUM_RST  = 16'd39015;
  localparam logic [RAW_LIM_W-1:0] WHITE_MIN_RST   = 10'd100;
  localparam logic [RAW_LIM_W-1:0] BLACK_MAX_RST   = 10'd30;
  localparam logic [HUE_LIM_W-1:0] HUE_RED_YEL_RST = 13'd341;
  localparam logic [HUE_LIM_W-1:0] HUE_YEL_GRN_RST = 13'd1024;
  localparam logic [HUE_LIM_W-1:0] HUE_GRN_BLU_RST = 13'd2048;
  localparam logic [HUE_LIM_W-1:0] HUE_BLU_RED_RST = 13'd3413;

  typedef enum logic [CODE_W-1:0] {
    CODE_NONE   = 3'd0,
    CODE_BLACK  = 3'd1,
    CODE_BLUE   = 3'd2,
    CODE_GREEN  = 3'd3,
    CODE_YELLOW = 3'd4,
    CODE_RED    = 3'd5,
    CODE_WHITE  = 3'd6,
    CODE_GRAY   = 3'd7
  } color_code_e;

  typedef struct packed {
    logic [SUM_LIM_W-1:0] dark_sum_limit;
    logic [SUM_LIM_W-1:0] bright_sum_limit;
    logic [RAW_LIM_W-1:0] white_min_raw;
    logic [RAW_LIM_W-1:0] black_max_raw;
    logic [HUE_LIM_W-1:0] hue_red_yellow;
    logic [HUE_LIM_W-1:0] hue_yellow_green;
    logic [HUE_LIM_W-1:0] hue_green_blue;
    logic [HUE_LIM_W-1:0] hue_blue_red;
  } cfg_t;

  // Side information that rides along with the hue through the divider.
  typedef struct packed {
    logic        decided;   // code already fixed before the hue is needed
    color_code_e code;
    logic        red_hi;    // green band shows as gray
    logic        blue_hi;   // green band shows as blue
  } side_t;

endpackage

/* rtl/rgbcc_prep.sv */
`timescale 1ns / 1ps

// First stage: clamping, luma test and raw-channel thresholds.
module rgbcc_prep #(
  parameter int SAMPLE_BITS = rgbcc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic [rgbcc_pkg::KIND_W-1:0]  kind_i,
  input  logic [SAMPLE_BITS-1:0]        red_raw_i,
  input  logic [SAMPLE_BITS-1:0]        green_raw_i,
  input  logic [SAMPLE_BITS-1:0]        blue_raw_i,
  input  rgbcc_pkg::cfg_t               cfg_i,
  output logic                          valid_o,
  output logic [rgbcc_pkg::CH_W-1:0]    r_o,
  output logic [rgbcc_pkg::CH_W-1:0]    g_o,
  output logic [rgbcc_pkg::CH_W-1:0]    b_o,
  output rgbcc_pkg::side_t              side_o
);
  import rgbcc_pkg::*;

  localparam int RW = (SAMPLE_BITS > RAW_LIM_W) ? SAMPLE_BITS : RAW_LIM_W;

  logic [CH_W-1:0]        r_c, g_c, b_c;
  logic [SAMPLE_BITS-1:0] raw_min, raw_max;
  logic [LUMA_W-1:0]      luma;
  side_t                  side_d;
  logic                   valid_q;
  logic [CH_W-1:0]        r_q, g_q, b_q;
  side_t                  side_q;

  // Clamp each channel to the 8-bit range.
  always_comb begin
    r_c = (red_raw_i   > SAMPLE_BITS'(CLAMP_MAX)) ? CLAMP_MAX : red_raw_i[CH_W-1:0];
    g_c = (green_raw_i > SAMPLE_BITS'(CLAMP_MAX)) ? CLAMP_MAX : green_raw_i[CH_W-1:0];
    b_c = (blue_raw_i  > SAMPLE_BITS'(CLAMP_MAX)) ? CLAMP_MAX : blue_raw_i[CH_W-1:0];
  end

  // Raw extremes and the luma sum of the clamped channels.
  always_comb begin
    raw_min = (red_raw_i < green_raw_i) ? red_raw_i : green_raw_i;
    raw_min = (raw_min < blue_raw_i) ? raw_min : blue_raw_i;
    raw_max = (red_raw_i > green_raw_i) ? red_raw_i : green_raw_i;
    raw_max = (raw_max > blue_raw_i) ? raw_max : blue_raw_i;
    luma = LUMA_R * LUMA_W'(r_c) + LUMA_G * LUMA_W'(g_c) + LUMA_B * LUMA_W'(b_c);
  end

  // Decisions that do not need the hue.
  always_comb begin
    side_d.decided = 1'b1;
    side_d.code    = CODE_NONE;
    side_d.red_hi  = (r_c > GRAY_RED_MIN);
    side_d.blue_hi = (b_c > BLUE_MIN);
    if (kind_i inside {KIND_BW, KIND_BGW}) begin
      if (luma < cfg_i.dark_sum_limit) begin
        side_d.code = CODE_BLACK;
      end else if (luma > cfg_i.bright_sum_limit) begin
        side_d.code = CODE_WHITE;
      end else begin
        side_d.code = (kind_i == KIND_BGW) ? CODE_GRAY : CODE_BLACK;
      end
    end else if (RW'(raw_min) > RW'(cfg_i.white_min_raw)) begin
      side_d.code = CODE_WHITE;
    end else if (RW'(raw_max) < RW'(cfg_i.black_max_raw)) begin
      side_d.code = CODE_BLACK;
    end else begin
      side_d.decided = 1'b0;
    end
  end

  // Stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      r_q    <= r_c;
      g_q    <= g_c;
      b_q    <= b_c;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign r_o     = r_q;
  assign g_o     = g_q;
  assign b_o     = b_q;
  assign side_o  = side_q;

endmodule

/* rtl/rgbcc_hue_num.sv */
`timescale 1ns / 1ps

// Second stage: hue numerator and divisor 6*(max-min) of the clamped channels.
module rgbcc_hue_num (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic [rgbcc_pkg::CH_W-1:0]    r_i,
  input  logic [rgbcc_pkg::CH_W-1:0]    g_i,
  input  logic [rgbcc_pkg::CH_W-1:0]    b_i,
  input  rgbcc_pkg::side_t              side_i,
  output logic                          valid_o,
  output logic [rgbcc_pkg::DIV_W-1:0]   rem_o,
  output logic [rgbcc_pkg::DIV_W-1:0]   dvs_o,
  output rgbcc_pkg::side_t              side_o
);
  import rgbcc_pkg::*;

  logic [CH_W-1:0]  mx, mn, dlt;
  logic [DIV_W:0]   d1, d2, d4, d6, num;
  logic [DIV_W-1:0] rem_d, dvs_d;
  logic             valid_q;
  logic [DIV_W-1:0] rem_q, dvs_q;
  side_t            side_q;

  // Channel spread and its multiples.
  always_comb begin
    mx  = (r_i > g_i) ? r_i : g_i;
    mx  = (mx > b_i) ? mx : b_i;
    mn  = (r_i < g_i) ? r_i : g_i;
    mn  = (mn < b_i) ? mn : b_i;
    dlt = mx - mn;
    d1  = (DIV_W + 1)'(dlt);
    d2  = {d1[DIV_W-1:0], 1'b0};
    d4  = {d1[DIV_W-2:0], 2'b00};
    d6  = d4 + d2;
  end

  // Numerator by the channel holding the maximum; red wins ties, then green.
  // All sums stay below 6*spread, so modular arithmetic is exact here.
  always_comb begin
    if (r_i == mx) begin
      if (g_i >= b_i) begin
        num = (DIV_W + 1)'(g_i - b_i);
      end else begin
        num = d6 - (DIV_W + 1)'(b_i - g_i);
      end
    end else if (g_i == mx) begin
      num = d2 + (DIV_W + 1)'(b_i) - (DIV_W + 1)'(r_i);
    end else begin
      num = d4 + (DIV_W + 1)'(r_i) - (DIV_W + 1)'(g_i);
    end
    // Equal channels give hue zero: numerator 0 over a divisor of 1.
    if (dlt == '0) begin
      rem_d = '0;
      dvs_d = DIV_W'(1);
    end else begin
      rem_d = num[DIV_W-1:0];
      dvs_d = d6[DIV_W-1:0];
    end
  end

  // Stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign dvs_o   = dvs_q;
  assign side_o  = side_q;

endmodule

/* rtl/rgbcc_div_stage.sv */
`timescale 1ns / 1ps

// One restoring-division step: produces one quotient bit of the hue.
module rgbcc_div_stage #(
  parameter int QW = rgbcc_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic [rgbcc_pkg::DIV_W-1:0]   rem_i,
  input  logic [rgbcc_pkg::DIV_W-1:0]   dvs_i,
  input  logic [QW-1:0]                 q_i,
  input  rgbcc_pkg::side_t              side_i,
  output logic                          valid_o,
  output logic [rgbcc_pkg::DIV_W-1:0]   rem_o,
  output logic [rgbcc_pkg::DIV_W-1:0]   dvs_o,
  output logic [QW-1:0]                 q_o,
  output rgbcc_pkg::side_t              side_o
);
  import rgbcc_pkg::*;

  logic [DIV_W:0]   shifted, diff;
  logic             take;
  logic [DIV_W-1:0] rem_d;
  logic [QW-1:0]    q_d;
  logic             valid_q;
  logic [DIV_W-1:0] rem_q, dvs_q;
  logic [QW-1:0]    q_q;
  side_t            side_q;

  // Double the remainder and subtract the divisor where it fits.
  always_comb begin
    shifted = {rem_i, 1'b0};
    diff    = shifted - {1'b0, dvs_i};
    take    = (shifted >= {1'b0, dvs_i});
    rem_d   = take ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    q_d     = {q_i[QW-2:0], take};
  end

  // Stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      rem_q  <= rem_d;
      dvs_q  <= dvs_i;
      q_q    <= q_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign dvs_o   = dvs_q;
  assign q_o     = q_q;
  assign side_o  = side_q;

endmodule

/* rtl/rgbcc_band.sv */
`timescale 1ns / 1ps

// Last stage: hue band selection and the output register.
module rgbcc_band #(
  parameter int QW = rgbcc_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic [QW-1:0]                 q_i,
  input  rgbcc_pkg::side_t              side_i,
  input  rgbcc_pkg::cfg_t               cfg_i,
  output logic                          valid_o,
  output logic [rgbcc_pkg::CODE_W-1:0]  color_code_o
);
  import rgbcc_pkg::*;

  localparam int CW = (QW > HUE_LIM_W) ? QW : HUE_LIM_W;

  logic [CW-1:0] q;
  color_code_e   code_d;
  logic          valid_q;
  color_code_e   code_q;

  // Band tests on the quantized hue, with the green-band overrides.
  always_comb begin
    q = CW'(q_i);
    if (side_i.decided) begin
      code_d = side_i.code;
    end else if (q < CW'(cfg_i.hue_red_yellow) || q >= CW'(cfg_i.hue_blue_red)) begin
      code_d = CODE_RED;
    end else if (q < CW'(cfg_i.hue_yellow_green)) begin
      code_d = CODE_YELLOW;
    end else if (q < CW'(cfg_i.hue_green_blue)) begin
      if (side_i.red_hi) begin
        code_d = CODE_GRAY;
      end else if (side_i.blue_hi) begin
        code_d = CODE_BLUE;
      end else begin
        code_d = CODE_GREEN;
      end
    end else if (q < CW'(cfg_i.hue_blue_red)) begin
      code_d = CODE_BLUE;
    end else begin
      code_d = CODE_NONE;
    end
  end

  // Output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // Output word.
  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      code_q <= code_d;
    end
  end

  assign valid_o      = valid_q;
  assign color_code_o = code_q;

endmodule

/* rtl/rgb_color_classifier_top.sv */
`timescale 1ns / 1ps

// RGB color classifier.
// Input channel: a word of mode (kind) and three raw RGB readings, taken at a
// clock edge where in_valid_i is high and in_stall_o is low. Output channel:
// one color code per input word, taken where out_valid_o is high and
// out_stall_i is low. Words leave in the order they entered.
// The pipeline has one stage for clamping and the luma and raw thresholds,
// one for the hue numerator, one restoring-division stage per hue fraction
// bit, and the band stage that holds the output register. Throughput is one
// word per cycle while in_stall_o is low. A stall from the receiver freezes
// only the stages that are full and have no free stage in front; empty stages
// keep filling, and in_stall_o rises only once the whole pipeline is full.
// Nothing is dropped or repeated. Reset empties the pipeline and loads the
// default thresholds. Registers are written through cfg_we_i / cfg_idx_i /
// cfg_data_i; the user must write them only while the block is idle, which
// the block does not enforce. Bits above a register's width are dropped.
module rgb_color_classifier_top #(
  parameter int SAMPLE_BITS   = rgbcc_pkg::SAMPLE_BITS_DEF,
  parameter int HUE_FRAC_BITS = rgbcc_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rgbcc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rgbcc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rgbcc_pkg::KIND_W-1:0]      kind_i,
  input  logic [SAMPLE_BITS-1:0]            red_raw_i,
  input  logic [SAMPLE_BITS-1:0]            green_raw_i,
  input  logic [SAMPLE_BITS-1:0]            blue_raw_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rgbcc_pkg::CODE_W-1:0]      color_code_o
);
  import rgbcc_pkg::*;

  localparam int NST = HUE_FRAC_BITS + 3;

  cfg_t                  cfg_q;
  logic [NST-1:0]        vld;
  logic [NST-1:0]        rdy;
  logic [CH_W-1:0]       r_w, g_w, b_w;
  side_t                 side_p;
  logic [DIV_W-1:0]      rem_w [0:HUE_FRAC_BITS-1];
  logic [DIV_W-1:0]      dvs_w [0:HUE_FRAC_BITS-1];
  logic [HUE_FRAC_BITS-1:0] q_w [0:HUE_FRAC_BITS];
  side_t                 side_w [0:HUE_FRAC_BITS];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dark_sum_limit   <= DARK_SUM_RST;
      cfg_q.bright_sum_limit <= BRIGHT_SUM_RST;
      cfg_q.white_min_raw    <= WHITE_MIN_RST;
      cfg_q.black_max_raw    <= BLACK_MAX_RST;
      cfg_q.hue_red_yellow   <= HUE_RED_YEL_RST;
      cfg_q.hue_yellow_green <= HUE_YEL_GRN_RST;
      cfg_q.hue_green_blue   <= HUE_GRN_BLU_RST;
      cfg_q.hue_blue_red     <= HUE_BLU_RED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DARK_SUM:    cfg_q.dark_sum_limit   <= cfg_data_i;
        REG_BRIGHT_SUM:  cfg_q.bright_sum_limit <= cfg_data_i;
        REG_WHITE_MIN:   cfg_q.white_min_raw    <= cfg_data_i[RAW_LIM_W-1:0];
        REG_BLACK_MAX:   cfg_q.black_max_raw    <= cfg_data_i[RAW_LIM_W-1:0];
        REG_HUE_RED_YEL: cfg_q.hue_red_yellow   <= cfg_data_i[HUE_LIM_W-1:0];
        REG_HUE_YEL_GRN: cfg_q.hue_yellow_green <= cfg_data_i[HUE_LIM_W-1:0];
        REG_HUE_GRN_BLU: cfg_q.hue_green_blue   <= cfg_data_i[HUE_LIM_W-1:0];
        REG_HUE_BLU_RED: cfg_q.hue_blue_red     <= cfg_data_i[HUE_LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or the stage in front of it loads.
  assign rdy[NST-1] = !vld[NST-1] || !out_stall_i;
  for (genvar k = 0; k < NST - 1; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  assign in_stall_o = !rdy[0];

  rgbcc_prep #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (rdy[0]),
    .valid_i     (in_valid_i),
    .kind_i      (kind_i),
    .red_raw_i   (red_raw_i),
    .green_raw_i (green_raw_i),
    .blue_raw_i  (blue_raw_i),
    .cfg_i       (cfg_q),
    .valid_o     (vld[0]),
    .r_o         (r_w),
    .g_o         (g_w),
    .b_o         (b_w),
    .side_o      (side_p)
  );

  rgbcc_hue_num u_hue_num (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (rdy[1]),
    .valid_i (vld[0]),
    .r_i     (r_w),
    .g_i     (g_w),
    .b_i     (b_w),
    .side_i  (side_p),
    .valid_o (vld[1]),
    .rem_o   (rem_w[0]),
    .dvs_o   (dvs_w[0]),
    .side_o  (side_w[0])
  );

  assign q_w[0] = '0;

  // Divider chain: one quotient bit per stage, most significant first.
  for (genvar k = 0; k < HUE_FRAC_BITS; k++) begin : g_div
    if (k < HUE_FRAC_BITS - 1) begin : g_mid
      rgbcc_div_stage #(
        .QW (HUE_FRAC_BITS)
      ) u_div (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .adv_i   (rdy[k+2]),
        .valid_i (vld[k+1]),
        .rem_i   (rem_w[k]),
        .dvs_i   (dvs_w[k]),
        .q_i     (q_w[k]),
        .side_i  (side_w[k]),
        .valid_o (vld[k+2]),
        .rem_o   (rem_w[k+1]),
        .dvs_o   (dvs_w[k+1]),
        .q_o     (q_w[k+1]),
        .side_o  (side_w[k+1])
      );
    end else begin : g_last
      rgbcc_div_stage #(
        .QW (HUE_FRAC_BITS)
      ) u_div (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .adv_i   (rdy[k+2]),
        .valid_i (vld[k+1]),
        .rem_i   (rem_w[k]),
        .dvs_i   (dvs_w[k]),
        .q_i     (q_w[k]),
        .side_i  (side_w[k]),
        .valid_o (vld[k+2]),
        .rem_o   (),
        .dvs_o   (),
        .q_o     (q_w[k+1]),
        .side_o  (side_w[k+1])
      );
    end
  end

  rgbcc_band #(
    .QW (HUE_FRAC_BITS)
  ) u_band (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (rdy[NST-1]),
    .valid_i      (vld[NST-2]),
    .q_i          (q_w[HUE_FRAC_BITS]),
    .side_i       (side_w[HUE_FRAC_BITS]),
    .cfg_i        (cfg_q),
    .valid_o      (vld[NST-1]),
    .color_code_o (color_code_o)
  );

  assign out_valid_o = vld[NST-1];

endmodule

/* tb/rgb_color_classifier_checker.sv */
`timescale 1ns / 1ps

// Scoreboard of the RGB color classifier. It keeps its own copy of the
// threshold registers, predicts a color code for every word that enters and
// compares it with the words that leave, in order.
module rgb_color_classifier_checker
  import rgbcc_pkg::*;
#(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [KIND_W-1:0]      kind_i,
  input  logic [SAMPLE_BITS-1:0] red_raw_i,
  input  logic [SAMPLE_BITS-1:0] green_raw_i,
  input  logic [SAMPLE_BITS-1:0] blue_raw_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [CODE_W-1:0]      color_code_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam cfg_t LIMITS_RST = {DARK_SUM_RST, BRIGHT_SUM_RST, WHITE_MIN_RST, BLACK_MAX_RST,
                                 HUE_RED_YEL_RST, HUE_YEL_GRN_RST, HUE_GRN_BLU_RST,
                                 HUE_BLU_RED_RST};

  // One word in flight: the code it should produce and the sample it came from.
  typedef struct {
    color_code_e            code;
    logic [KIND_W-1:0]      kind;
    logic [SAMPLE_BITS-1:0] red;
    logic [SAMPLE_BITS-1:0] green;
    logic [SAMPLE_BITS-1:0] blue;
  } color_word_t;

  cfg_t        limits;
  color_word_t codes_due[$];
  color_word_t taken_word;
  color_word_t due_word;
  int          mismatches = 0;
  int          words_due = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = words_due;

  // Classifies one sample against the given thresholds.
  function automatic color_code_e classify_sample(cfg_t lim, logic [KIND_W-1:0] kind,
                                                  logic [SAMPLE_BITS-1:0] red_raw,
                                                  logic [SAMPLE_BITS-1:0] green_raw,
                                                  logic [SAMPLE_BITS-1:0] blue_raw);
    logic [31:0] r, g, b, mx, mn, span, num, hue_q, luma;
    logic [SAMPLE_BITS-1:0] raw_min, raw_max;
    r = (red_raw > CLAMP_MAX) ? 32'(CLAMP_MAX) : 32'(red_raw);
    g = (green_raw > CLAMP_MAX) ? 32'(CLAMP_MAX) : 32'(green_raw);
    b = (blue_raw > CLAMP_MAX) ? 32'(CLAMP_MAX) : 32'(blue_raw);

    // Brightness modes look only at the luma sum.
    if (kind == KIND_BW || kind == KIND_BGW) begin
      luma = 32'(LUMA_R) * r + 32'(LUMA_G) * g + 32'(LUMA_B) * b;
      if (luma < 32'(lim.dark_sum_limit)) return CODE_BLACK;
      if (luma > 32'(lim.bright_sum_limit)) return CODE_WHITE;
      if (kind == KIND_BGW) return CODE_GRAY;
      return CODE_BLACK;
    end

    // Color mode: raw extremes decide white and black first.
    raw_min = red_raw;
    if (green_raw < raw_min) raw_min = green_raw;
    if (blue_raw < raw_min) raw_min = blue_raw;
    raw_max = red_raw;
    if (green_raw > raw_max) raw_max = green_raw;
    if (blue_raw > raw_max) raw_max = blue_raw;
    if (32'(raw_min) > 32'(lim.white_min_raw)) return CODE_WHITE;
    if (32'(raw_max) < 32'(lim.black_max_raw)) return CODE_BLACK;

    // Exact hue of the clamped channels; red wins ties, then green.
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    span = mx - mn;
    if (span == 0) begin
      hue_q = 0;
    end else begin
      if (r == mx) begin
        if (g >= b) num = g - b;
        else num = 6 * span - (b - g);
      end else if (g == mx) begin
        num = 2 * span + b - r;
      end else begin
        num = 4 * span + r - g;
      end
      hue_q = (num << HUE_FRAC_BITS) / (6 * span);
    end

    // Hue bands, with the gray and blue overrides inside the green band.
    if (hue_q < 32'(lim.hue_red_yellow) || hue_q >= 32'(lim.hue_blue_red)) return CODE_RED;
    if (hue_q < 32'(lim.hue_yellow_green)) return CODE_YELLOW;
    if (hue_q < 32'(lim.hue_green_blue)) begin
      if (r > 32'(GRAY_RED_MIN)) return CODE_GRAY;
      if (b > 32'(BLUE_MIN)) return CODE_BLUE;
      return CODE_GREEN;
    end
    if (hue_q < 32'(lim.hue_blue_red)) return CODE_BLUE;
    return CODE_NONE;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Register shadow, prediction on input words and comparison on output words.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits <= LIMITS_RST;
      codes_due.delete();
      words_due <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DARK_SUM:    limits.dark_sum_limit   <= cfg_data_i[SUM_LIM_W-1:0];
          REG_BRIGHT_SUM:  limits.bright_sum_limit <= cfg_data_i[SUM_LIM_W-1:0];
          REG_WHITE_MIN:   limits.white_min_raw    <= cfg_data_i[RAW_LIM_W-1:0];
          REG_BLACK_MAX:   limits.black_max_raw    <= cfg_data_i[RAW_LIM_W-1:0];
          REG_HUE_RED_YEL: limits.hue_red_yellow   <= cfg_data_i[HUE_LIM_W-1:0];
          REG_HUE_YEL_GRN: limits.hue_yellow_green <= cfg_data_i[HUE_LIM_W-1:0];
          REG_HUE_GRN_BLU: limits.hue_green_blue   <= cfg_data_i[HUE_LIM_W-1:0];
          REG_HUE_BLU_RED: limits.hue_blue_red     <= cfg_data_i[HUE_LIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        taken_word.kind  = kind_i;
        taken_word.red   = red_raw_i;
        taken_word.green = green_raw_i;
        taken_word.blue  = blue_raw_i;
        taken_word.code  = classify_sample(limits, kind_i, red_raw_i, green_raw_i, blue_raw_i);
        codes_due.push_back(taken_word);
      end
      if (out_valid_i && !out_stall_i) begin
        if (codes_due.size() == 0) begin
          report_mismatch($sformatf("output word %0d with nothing due", color_code_i));
        end else begin
          due_word = codes_due.pop_front();
          if (color_code_i !== due_word.code) begin
            report_mismatch($sformatf("kind %0d rgb %0d/%0d/%0d: code %0d, due %0d",
                                      due_word.kind, due_word.red, due_word.green,
                                      due_word.blue, color_code_i, due_word.code));
          end
        end
      end
      words_due <= codes_due.size();
    end
  end

endmodule

/* tb/tb_rgb_color_classifier_top.sv */
`timescale 1ns / 1ps

module tb_rgb_color_classifier_top;
  import rgbcc_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam logic [KIND_W-1:0] KIND_COLOR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int PHASES = 9;
  localparam int WORDS_PER_PHASE = 170;
  localparam realtime WATCHDOG_NS = 1000000.0;

  localparam cfg_t LIMITS_RST = {DARK_SUM_RST, BRIGHT_SUM_RST, WHITE_MIN_RST, BLACK_MAX_RST,
                                 HUE_RED_YEL_RST, HUE_YEL_GRN_RST, HUE_GRN_BLU_RST,
                                 HUE_BLU_RED_RST};

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = REG_DARK_SUM;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [KIND_W-1:0]     kind_i = KIND_BW;
  logic [SB-1:0]         red_raw_i = '0;
  logic [SB-1:0]         green_raw_i = '0;
  logic [SB-1:0]         blue_raw_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [CODE_W-1:0]     color_code_o;

  int   mismatches;
  int   words_due;
  int   words_sent = 0;
  int   words_taken = 0;
  cfg_t stim_limits = LIMITS_RST;

  rgb_color_classifier_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .red_raw_i    (red_raw_i),
    .green_raw_i  (green_raw_i),
    .blue_raw_i   (blue_raw_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .color_code_o (color_code_o)
  );

  rgb_color_classifier_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .kind_i       (kind_i),
    .red_raw_i    (red_raw_i),
    .green_raw_i  (green_raw_i),
    .blue_raw_i   (blue_raw_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .color_code_i (color_code_o),
    .fail_count_o (mismatches),
    .pending_o    (words_due)
  );

  // 100 MHz clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Offers one word after a random gap and holds it until it is taken.
  // Out of every 128 words, the gaps stop for the first 24.
  task automatic put_word(input logic [KIND_W-1:0] kind, input logic [SB-1:0] r,
                          input logic [SB-1:0] g, input logic [SB-1:0] b);
    int gap;
    gap = ((words_sent % 128) < 24) ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    red_raw_i   <= r;
    green_raw_i <= g;
    blue_raw_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  // Picks a random sample, mostly in color mode and mostly one that gets
  // past the raw white and black tests so that the hue bands are reached.
  task automatic draw_word(output logic [KIND_W-1:0] kind, output logic [SB-1:0] r,
                           output logic [SB-1:0] g, output logic [SB-1:0] b);
    int pick;
    int level;
    logic [SB-1:0] ch [3];
    logic [SB-1:0] corner [6];
    corner = '{10'd0, 10'd1, 10'd254, 10'd255, 10'd256, 10'd1023};
    pick = $urandom_range(0, 9);
    if (pick < 7) kind = KIND_COLOR;
    else if (pick == 7) kind = KIND_SPARE;
    else if (pick == 8) kind = KIND_BW;
    else kind = KIND_BGW;
    case ($urandom_range(0, 7))
      0: begin
        foreach (ch[i]) ch[i] = SB'($urandom_range(0, 1023));
      end
      5: begin
        level = $urandom_range(0, 300);
        foreach (ch[i]) ch[i] = SB'(level);
        if ($urandom_range(0, 3) != 0) ch[$urandom_range(0, 2)] = SB'($urandom_range(0, 300));
      end
      6: begin
        level = $urandom_range(0, 255);
        foreach (ch[i]) ch[i] = SB'(level) ^ SB'($urandom_range(0, 7));
      end
      7: begin
        foreach (ch[i]) ch[i] = corner[$urandom_range(0, 5)];
      end
      default: begin
        foreach (ch[i]) ch[i] = SB'($urandom_range(0, 300));
        ch[$urandom_range(0, 2)] = SB'($urandom_range(0, 32'(stim_limits.white_min_raw)));
      end
    endcase
    r = ch[0];
    g = ch[1];
    b = ch[2];
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Writes all eight thresholds; narrow registers get junk in the unused
  // upper bits, which the block has to drop.
  task automatic load_limits(input cfg_t lim);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_DARK_SUM, lim.dark_sum_limit);
    write_reg(REG_BRIGHT_SUM, lim.bright_sum_limit);
    write_reg(REG_WHITE_MIN, {junk[15:10], lim.white_min_raw});
    write_reg(REG_BLACK_MAX, {junk[9:4], lim.black_max_raw});
    write_reg(REG_HUE_RED_YEL, {junk[2:0], lim.hue_red_yellow});
    write_reg(REG_HUE_YEL_GRN, {junk[5:3], lim.hue_yellow_green});
    write_reg(REG_HUE_GRN_BLU, {junk[8:6], lim.hue_green_blue});
    write_reg(REG_HUE_BLU_RED, {junk[11:9], lim.hue_blue_red});
    cfg_we_i <= 1'b0;
    stim_limits = lim;
  endtask

  // Stops offering and waits until every word in flight has come out.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_due != 0) @(posedge clk_i);
  endtask

  // Thresholds for one phase: fixed corner settings first, then random ones
  // with ordered hue limits.
  function automatic cfg_t phase_limits(int phase);
    cfg_t lim;
    logic [HUE_LIM_W-1:0] edge_q [4];
    logic [HUE_LIM_W-1:0] tmp;
    case (phase)
      0: lim = LIMITS_RST;
      1: lim = {16'd0, 16'd0, 10'd0, 10'd0, 13'd0, 13'd0, 13'd0, 13'd0};
      2: lim = {16'hffff, 16'hffff, 10'd1023, 10'd0, 13'd4096, 13'd4096, 13'd4096, 13'd4096};
      3: lim = {16'd32768, 16'd16000, 10'd1023, 10'd1023, 13'd0, 13'd0, 13'd0, 13'd4096};
      4: lim = {16'd20000, 16'd50000, 10'd1023, 10'd0, 13'd0, 13'd0, 13'd8191, 13'd8191};
      default: begin
        lim.dark_sum_limit   = SUM_LIM_W'($urandom_range(0, 30000));
        lim.bright_sum_limit = SUM_LIM_W'($urandom_range(20000, 65535));
        lim.white_min_raw    = RAW_LIM_W'($urandom_range(40, 400));
        lim.black_max_raw    = RAW_LIM_W'($urandom_range(0, 60));
        foreach (edge_q[i]) edge_q[i] = HUE_LIM_W'($urandom_range(0, 4096));
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3 - i; j++) begin
            if (edge_q[j] > edge_q[j+1]) begin
              tmp         = edge_q[j];
              edge_q[j]   = edge_q[j+1];
              edge_q[j+1] = tmp;
            end
          end
        end
        lim.hue_red_yellow   = edge_q[0];
        lim.hue_yellow_green = edge_q[1];
        lim.hue_green_blue   = edge_q[2];
        lim.hue_blue_red     = edge_q[3];
      end
    endcase
    return lim;
  endfunction

  // Receiver: random stalls per word, calm stretches, and two long hold-offs
  // that let the pipeline fill up and push back on the sender.
  initial begin : receive_words
    int hold;
    wait (rst_ni);
    forever begin
      if (words_taken == 300 || words_taken == 1000) hold = 80;
      else if ((words_taken % 160) < 30) hold = 0;
      else hold = $urandom_range(0, 3);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      words_taken++;
    end
  end

  // Reset, directed samples at the reset thresholds, then random phases.
  initial begin : drive_words
    logic [KIND_W-1:0] kind;
    logic [SB-1:0]     r, g, b;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Brightness modes at the extremes and in the middle band.
    put_word(KIND_BW, 10'd0, 10'd0, 10'd0);
    put_word(KIND_BW, 10'd1023, 10'd1023, 10'd1023);
    put_word(KIND_BW, 10'd128, 10'd128, 10'd128);
    put_word(KIND_BGW, 10'd128, 10'd128, 10'd128);
    put_word(KIND_BGW, 10'd0, 10'd0, 10'd0);
    put_word(KIND_BGW, 10'd1023, 10'd0, 10'd1023);
    // Color mode: raw white and black tests and their edges.
    put_word(KIND_COLOR, 10'd101, 10'd101, 10'd101);
    put_word(KIND_COLOR, 10'd100, 10'd1023, 10'd1023);
    put_word(KIND_COLOR, 10'd29, 10'd0, 10'd0);
    put_word(KIND_COLOR, 10'd30, 10'd0, 10'd0);
    // Every hue band, the green-band overrides and the magenta wrap.
    put_word(KIND_COLOR, 10'd255, 10'd255, 10'd0);
    put_word(KIND_COLOR, 10'd0, 10'd255, 10'd0);
    put_word(KIND_COLOR, 10'd60, 10'd255, 10'd0);
    put_word(KIND_COLOR, 10'd0, 10'd255, 10'd80);
    put_word(KIND_COLOR, 10'd0, 10'd0, 10'd255);
    put_word(KIND_COLOR, 10'd255, 10'd0, 10'd255);
    // Equal channels, ties for the maximum, clamping and the spare kind.
    put_word(KIND_COLOR, 10'd50, 10'd50, 10'd50);
    put_word(KIND_COLOR, 10'd200, 10'd200, 10'd0);
    put_word(KIND_COLOR, 10'd0, 10'd200, 10'd200);
    put_word(KIND_COLOR, 10'd1023, 10'd0, 10'd0);
    put_word(KIND_SPARE, 10'd200, 10'd0, 10'd40);
    put_word(KIND_SPARE, 10'd0, 10'd1023, 10'd0);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_block();
      load_limits(phase_limits(phase));
      repeat (WORDS_PER_PHASE) begin
        draw_word(kind, r, g, b);
        put_word(kind, r, g, b);
      end
    end

    drain_block();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && words_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
